>>> rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranging block.
// Used by uer_dist and ultrasonic_echo_ranging_top; depends on nothing else.
package uer_pkg;

    // Fixed geometry of the block.
    localparam int CHANNELS    = 3;
    localparam int COUNT_WIDTH = 24;
    localparam int DIST_WIDTH  = 19;

    // Register reset values: a 60 ms period and a 10 us pulse at 204 ticks per us.
    localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET = 24'd12240000;
    localparam logic [COUNT_WIDTH-1:0] PULSE_RESET  = 24'd2040;

    // Conversion divisors.
    localparam logic [7:0] TICKS_PER_US = 8'd204;
    localparam logic [7:0] CM_DIVISOR   = 8'd58;
    localparam logic [7:0] INCH_DIVISOR = 8'd148;

    // Reciprocals floor(2^32 / d); the quotient they give is at most one low.
    localparam logic [24:0] RECIP_US   = 25'd21053761;
    localparam logic [26:0] RECIP_CM   = 27'd74051160;
    localparam logic [26:0] RECIP_INCH = 27'd29020049;

    localparam logic [DIST_WIDTH-1:0] Q8_MAX = 19'h7FFFF;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PERIOD = 2'd0,
        CFG_PULSE  = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_idx;

    // Per-item data that rides alongside the distance conversion.
    typedef struct packed {
        logic                   trigger;
        logic [COUNT_WIDTH-1:0] width_ticks;
        logic                   is_query;
        logic                   unit;
    } t_side;

endpackage

>>> rtl/ultrasonic_echo_ranging_top.sv
// Top level of the multi-channel ultrasonic echo ranging controller.
// Depends on uer_pkg and instantiates uer_dist.
//
// The block takes one item per clock cycle unless the output stalls: timer ticks,
// echo edges and distance queries. Each item updates the counter, trigger and
// per-channel echo registers in the cycle it is accepted, and its result word
// leaves after the reciprocal-multiply stages of the distance conversion. The
// pipeline stalls as a whole while the result word is not taken, so the input is
// ready whenever the output stage is empty or being drained. Configuration writes
// are always ready and take effect at the next edge; write them only while no
// item is in flight.
module ultrasonic_echo_ranging_top
    import uer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [1:0] channel, [2] rising, [3] unit, [7:4] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    // Result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [0] trigger, [19:1] distance_q8,
                                     // [43:20] width_ticks, [47:44] zero
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // Configuration registers.
    logic [COUNT_WIDTH-1:0] r_period;
    logic [COUNT_WIDTH-1:0] r_pulse;
    logic [CHANNELS-1:0]    r_enable;

    // Timing state.
    logic                   r_count_unused_guard;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_trig, n_trig;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] r_rise, n_rise;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] r_width, n_width;

    // Decode of the incoming item.
    t_cmd                   in_cmd;
    logic [1:0]             in_ch;
    logic                   in_rising;
    logic                   in_unit;
    logic                   in_acc;
    logic                   pipe_en;
    logic                   ch_ok;
    logic                   ch_en;
    logic [COUNT_WIDTH-1:0] sel_rise;
    logic [COUNT_WIDTH-1:0] tick_next;
    logic [COUNT_WIDTH:0]   echo_span;
    t_side                  in_side;
    t_side                  out_side;
    logic [DIST_WIDTH-1:0]  out_dist;

    assign in_cmd    = t_cmd'(i_s_tuser);
    assign in_ch     = i_s_tdata[1:0];
    assign in_rising = i_s_tdata[2];
    assign in_unit   = i_s_tdata[3];

    // Whole pipeline moves unless a finished word is waiting.
    assign pipe_en     = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = pipe_en;
    assign in_acc      = i_s_tvalid && pipe_en;
    assign o_cfg_ready = 1'b1;

    // Channel lookup.
    always_comb begin
        ch_ok    = 1'b0;
        ch_en    = 1'b0;
        sel_rise = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (in_ch == 2'(i)) begin
                ch_ok    = 1'b1;
                ch_en    = r_enable[i];
                sel_rise = r_rise[i];
            end
        end
    end

    // Echo width, adding the period back when the counter wrapped.
    assign tick_next = r_count + 1'b1;
    assign echo_span = (r_count >= sel_rise)
                     ? {1'b0, r_count} - {1'b0, sel_rise}
                     : {1'b0, r_count} + {1'b0, r_period} - {1'b0, sel_rise};

    // State update for the accepted item.
    always_comb begin
        n_count = r_count;
        n_trig  = r_trig;
        n_rise  = r_rise;
        n_width = r_width;
        if (in_acc) begin
            case (in_cmd)
                CMD_TICK: begin
                    if (r_enable != '0) begin
                        if (tick_next >= r_period) begin
                            n_count = '0;
                            n_trig  = 1'b1;
                        end else begin
                            n_count = tick_next;
                            if (tick_next == r_pulse) begin
                                n_trig = 1'b0;
                            end
                        end
                    end
                end
                CMD_EDGE: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (ch_en && in_ch == 2'(i)) begin
                            if (in_rising) begin
                                n_rise[i] = r_count;
                            end else begin
                                n_width[i] = echo_span[COUNT_WIDTH-1:0];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Sideband word for the result, taken after the update.
    always_comb begin
        in_side.trigger     = n_trig;
        in_side.width_ticks = '0;
        in_side.is_query    = (in_cmd == CMD_QUERY) && ch_ok;
        in_side.unit        = in_unit;
        for (int i = 0; i < CHANNELS; i++) begin
            if (in_ch == 2'(i)) begin
                in_side.width_ticks = n_width[i];
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_pulse  <= PULSE_RESET;
            r_enable <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_PULSE:  r_pulse  <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[CHANNELS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Counter, trigger and echo registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_trig  <= 1'b0;
            r_rise  <= '0;
            r_width <= '0;
        end else begin
            r_count <= n_count;
            r_trig  <= n_trig;
            r_rise  <= n_rise;
            r_width <= n_width;
        end
    end

    // Flag the first cycle out of reset so checks skip it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_unused_guard <= 1'b0;
        end else begin
            r_count_unused_guard <= 1'b1;
        end
    end

    uer_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (pipe_en),
        .i_valid       (in_acc),
        .i_side        (in_side),
        .o_valid       (o_m_tvalid),
        .o_side        (out_side),
        .o_distance_q8 (out_dist)
    );

    assign o_m_tdata = {4'h0, out_side.width_ticks, out_dist, out_side.trigger};

    // An edge on a disabled channel must leave the echo registers alone.
    a_disabled_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_cmd == CMD_EDGE && !ch_en |=> $stable(r_width) && $stable(r_rise))
        else $error("echo registers changed on an ignored edge");

    // With every channel off, ticks hold the counter and the trigger.
    a_idle_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_unused_guard && in_acc && in_cmd == CMD_TICK && r_enable == '0
        |=> $stable(r_count) && $stable(r_trig))
        else $error("counter moved with all channels disabled");

    // Only queries carry a nonzero distance.
    a_dist_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !out_side.is_query |-> out_dist == '0)
        else $error("distance reported for a non-query item");

endmodule

>>> rtl/uer_dist.sv
// Distance conversion pipeline: echo width in ticks to Q.8 centimeters or inches.
// Depends on uer_pkg; instantiated by ultrasonic_echo_ranging_top.
module uer_dist
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_side                 i_side,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [DIST_WIDTH-1:0] o_distance_q8
);

    // Stage registers.
    logic        r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    t_side       r_a_side, r_b_side, r_c_side, r_d_side, r_e_side, r_f_side;
    logic [48:0] r_b_prod;
    logic [16:0] r_c_q0;
    logic [24:0] r_c_t;
    logic [24:0] r_d_x;
    logic [51:0] r_d_prod;
    logic [24:0] r_e_x;
    logic [19:0] r_e_q0;
    logic [27:0] r_e_t;
    logic [DIST_WIDTH-1:0] r_f_dist;

    // Next values of the arithmetic registers.
    logic [48:0] n_b_prod;
    logic [16:0] n_c_q0;
    logic [24:0] n_c_t;
    logic [24:0] c_rem;
    logic [16:0] c_us;
    logic [24:0] n_d_x;
    logic [26:0] d_recip;
    logic [51:0] n_d_prod;
    logic [7:0]  e_div;
    logic [19:0] n_e_q0;
    logic [27:0] n_e_t;
    logic [7:0]  f_div;
    logic [27:0] f_rem;
    logic [19:0] f_quot;
    logic [DIST_WIDTH-1:0] n_f_dist;

    // Microseconds: estimate by reciprocal, then one correction step.
    assign n_b_prod = 49'(r_a_side.width_ticks) * 49'(RECIP_US);
    assign n_c_q0   = r_b_prod[48:32];
    assign n_c_t    = 25'(n_c_q0) * 25'(TICKS_PER_US);

    assign c_rem = 25'(r_c_side.width_ticks) - r_c_t;
    assign c_us  = r_c_q0 + 17'(c_rem >= 25'(TICKS_PER_US));

    // Scale by 256 and divide by the unit's divisor the same way.
    assign n_d_x    = {c_us, 8'h00};
    assign d_recip  = r_c_side.unit ? RECIP_INCH : RECIP_CM;
    assign n_d_prod = 52'(n_d_x) * 52'(d_recip);

    assign e_div  = r_d_side.unit ? INCH_DIVISOR : CM_DIVISOR;
    assign n_e_q0 = r_d_prod[51:32];
    assign n_e_t  = 28'(n_e_q0) * 28'(e_div);

    assign f_div  = r_e_side.unit ? INCH_DIVISOR : CM_DIVISOR;
    assign f_rem  = 28'(r_e_x) - r_e_t;
    assign f_quot = r_e_q0 + 20'(f_rem >= 28'(f_div));

    // Saturate, and report zero for anything that is not a query.
    always_comb begin
        if (!r_e_side.is_query) begin
            n_f_dist = '0;
        end else if (f_quot > 20'(Q8_MAX)) begin
            n_f_dist = Q8_MAX;
        end else begin
            n_f_dist = f_quot[DIST_WIDTH-1:0];
        end
    end

    // Stage valid bits advance together whenever the pipeline is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_b_side <= r_a_side;
            r_b_prod <= n_b_prod;
            r_c_side <= r_b_side;
            r_c_q0   <= n_c_q0;
            r_c_t    <= n_c_t;
            r_d_side <= r_c_side;
            r_d_x    <= n_d_x;
            r_d_prod <= n_d_prod;
            r_e_side <= r_d_side;
            r_e_x    <= r_d_x;
            r_e_q0   <= n_e_q0;
            r_e_t    <= n_e_t;
            r_f_side <= r_e_side;
            r_f_dist <= n_f_dist;
        end
    end

    assign o_valid       = r_f_vld;
    assign o_side        = r_f_side;
    assign o_distance_q8 = r_f_dist;

endmodule

>>> test/ultrasonic_echo_ranging_top_test.sv
// Self-checking testbench for ultrasonic_echo_ranging_top: drives ticks, echo edges and
// distance queries, predicts every result word and compares it field by field.
// Depends on uer_pkg and the block's RTL only.
module ultrasonic_echo_ranging_top_test
    import uer_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 10;
    localparam int MAX_GAP       = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES  = 200;
    localparam int STALL_AFTER   = 400;
    localparam int PHASE_ITEMS   = 90;
    localparam int ITEM_TARGET   = 1320;
    localparam int RUN_LIMIT_NS  = 2000000;

    // Codes that the package leaves unnamed but the fields can carry.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Predicts the ranging state and holds the result words still to come.
    class t_echo_ranging_board;
        typedef struct packed {
            logic                   trig;
            logic [DIST_WIDTH-1:0]  distance;
            logic [COUNT_WIDTH-1:0] width;
        } t_range_word;

        logic [COUNT_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0] pulse;
        logic [CHANNELS-1:0]    enables;
        logic [COUNT_WIDTH-1:0] count;
        logic                   trig;
        logic [COUNT_WIDTH-1:0] rise_at [CHANNELS];
        logic [COUNT_WIDTH-1:0] width   [CHANNELS];
        t_range_word            pending_words [$];
        int                     errors;
        int                     checked;
        int                     nonzero_dist;

        function new();
            period  = PERIOD_RESET;
            pulse   = PULSE_RESET;
            enables = '0;
            count   = '0;
            trig    = 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                rise_at[c] = '0;
                width[c]   = '0;
            end
            errors       = 0;
            checked      = 0;
            nonzero_dist = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [COUNT_WIDTH-1:0] value);
            case (idx)
                CFG_PERIOD: period  = value;
                CFG_PULSE:  pulse   = value;
                CFG_ENABLE: enables = value[CHANNELS-1:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted item and queues the word it must produce.
        function void take_item(logic [1:0] cmd, logic [1:0] ch, logic rising, logic unit);
            t_range_word            w;
            logic [COUNT_WIDTH-1:0] nxt;
            longint unsigned        us;
            longint unsigned        q;
            bit                     ch_ok;
            ch_ok      = (ch < CHANNELS);
            w.distance = '0;
            case (cmd)
                CMD_TICK: begin
                    // The counter only runs while some channel listens.
                    if (enables != '0) begin
                        nxt = count + 1'b1;
                        if (nxt >= period) begin
                            count = '0;
                            trig  = 1'b1;
                        end else begin
                            count = nxt;
                            if (nxt == pulse) trig = 1'b0;
                        end
                    end
                end
                CMD_EDGE: begin
                    if (ch_ok && enables[ch]) begin
                        if (rising) begin
                            rise_at[ch] = count;
                        end else if (count >= rise_at[ch]) begin
                            width[ch] = count - rise_at[ch];
                        end else begin
                            // The counter wrapped during the echo.
                            width[ch] = count + period - rise_at[ch];
                        end
                    end
                end
                CMD_QUERY: begin
                    if (ch_ok) begin
                        us = width[ch] / TICKS_PER_US;
                        q  = (us << 8) / (unit ? INCH_DIVISOR : CM_DIVISOR);
                        w.distance = (q > Q8_MAX) ? Q8_MAX : q[DIST_WIDTH-1:0];
                        if (w.distance != '0) nonzero_dist++;
                    end
                end
                default: ;
            endcase
            w.trig  = trig;
            w.width = ch_ok ? width[ch] : '0;
            pending_words.push_back(w);
        endfunction

        task report(string what, logic [47:0] got, logic [47:0] want);
            errors++;
            $display("ERROR at result %0d: %s is %0h, expected %0h", checked, what, got, want);
        endtask

        // Compares one accepted result word with the oldest prediction.
        task check_word(logic [47:0] word);
            t_range_word want;
            if (pending_words.size() == 0) begin
                report("word with nothing pending", word, '0);
                return;
            end
            want = pending_words.pop_front();
            checked++;
            if (word[0] !== want.trig) report("trigger", 48'(word[0]), 48'(want.trig));
            if (word[19:1] !== want.distance) begin
                report("distance_q8", 48'(word[19:1]), 48'(want.distance));
            end
            if (word[43:20] !== want.width) begin
                report("width_ticks", 48'(word[43:20]), 48'(want.width));
            end
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;   // [1:0] channel, [2] rising, [3] unit, [7:4] zero
    logic [1:0]  i_s_tuser   = '0;   // [1:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [47:0] o_m_tdata;          // [0] trigger, [19:1] distance_q8, [43:20] width_ticks
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data  = '0;

    t_echo_ranging_board ranging;
    int   items_sent = 0;
    int   cfg_writes = 0;
    int   rx_left    = 0;
    bit   tx_no_idle = 1'b0;
    logic rx_no_idle = 1'b0;
    logic rx_stall   = 1'b0;

    ultrasonic_echo_ranging_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Output side: ready drops for a random pause after each accepted word unless rx_no_idle is set.
    always @(posedge i_clk) begin : rx_ready_gen
        int draw;
        if (!i_rst_n || rx_stall) begin
            i_m_tready <= 1'b0;
        end else if (i_m_tready) begin
            if (o_m_tvalid) begin
                draw = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
                if (draw != 0) begin
                    i_m_tready <= 1'b0;
                    rx_left    <= draw;
                end
            end
        end else if (rx_left > 1) begin
            rx_left <= rx_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            rx_left    <= 0;
        end
    end

    // Every accepted result word is checked at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) ranging.check_word(o_m_tdata);
    end

    // One long hold-off on the output while the input keeps offering words.
    initial begin : rx_long_stall
        wait (items_sent >= STALL_AFTER);
        @(posedge i_clk);
        rx_stall <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        rx_stall <= 1'b0;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("ultrasonic_echo_ranging_top_test: errors");
        $finish;
    end

    // Offers one word after a random gap and waits until the block takes it.
    task automatic send_item(logic [1:0] cmd, logic [1:0] ch, logic rising, logic unit);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, unit, rising, ch};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        ranging.take_item(cmd, ch, rising, unit);
        items_sent++;
    endtask

    // Any command on any channel, the unused code and channel included.
    task automatic send_random();
        int         r;
        logic [1:0] cmd;
        logic [1:0] ch;
        r = $urandom_range(0, 99);
        if (r < 40)      cmd = CMD_TICK;
        else if (r < 70) cmd = CMD_EDGE;
        else if (r < 95) cmd = CMD_QUERY;
        else             cmd = CMD_UNUSED;
        ch = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_item(cmd, ch, 1'($urandom), 1'($urandom));
    endtask

    task automatic write_register(logic [1:0] idx, logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ranging.write_reg(idx, value);
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // Stops offering words, waits for every pending word, then lets the pipe empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (ranging.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register setting followed by a run of random words.
    task automatic run_phase(int phase_no);
        logic [COUNT_WIDTH-1:0] per;
        logic [COUNT_WIDTH-1:0] pul;
        logic [CHANNELS-1:0]    en;
        bit                     big;
        int                     start;
        int                     n;
        int                     r;
        int                     guard;
        logic [1:0]             ch;
        case (phase_no)
            0: begin per = '0;     pul = '0;     en = 3'b111; big = 1'b0; end
            1: begin per = 24'd20; pul = 24'd7;  en = 3'b111; big = 1'b0; end
            2: begin per = '1;     pul = 24'd1;  en = 3'b111; big = 1'b1; end
            3: begin per = 24'd1;  pul = '1;     en = 3'b001; big = 1'b0; end
            4: begin per = 24'd5;  pul = 24'd5;  en = 3'b100; big = 1'b0; end
            default: begin
                big = ($urandom_range(0, 9) < 3);
                if (big) begin
                    per = ($urandom_range(0, 1) != 0) ? 24'($urandom)
                                                      : 24'($urandom_range(200, 300000));
                end else begin
                    per = 24'($urandom_range(1, 48));
                end
                case ($urandom_range(0, 3))
                    0: pul = '0;
                    1: pul = '1;
                    default: pul = big ? 24'($urandom) : 24'($urandom_range(1, per + 2));
                endcase
                en = ($urandom_range(0, 9) == 0) ? '0 : 3'($urandom_range(1, 7));
            end
        endcase
        write_register(CFG_PERIOD, per);
        write_register(CFG_PULSE, pul);
        write_register(CFG_ENABLE, 24'(en));
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle <= ($urandom_range(0, 3) == 0);

        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if (big) begin
                // Long period: mostly falls and queries against rises latched earlier.
                r  = $urandom_range(0, 99);
                ch = 2'($urandom_range(0, 2));
                if (r < 35)      send_item(CMD_EDGE, ch, 1'b0, 1'($urandom));
                else if (r < 70) send_item(CMD_QUERY, ch, 1'($urandom), 1'($urandom));
                else if (r < 88) send_item(CMD_TICK, ch, 1'($urandom), 1'($urandom));
                else if (r < 93) send_item(CMD_EDGE, ch, 1'b1, 1'($urandom));
                else             send_random();
            end else if ($urandom_range(0, 99) < 55) begin
                // A whole echo: rise, some ticks with a little noise, fall, query.
                ch = 2'($urandom_range(0, 2));
                send_item(CMD_EDGE, ch, 1'b1, 1'($urandom));
                n = $urandom_range(0, (per > 36) ? 40 : int'(per) + 4);
                repeat (n) begin
                    if ($urandom_range(0, 6) == 0) begin
                        send_random();
                    end else begin
                        send_item(CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom),
                                  1'($urandom));
                    end
                end
                send_item(CMD_EDGE, ch, 1'b0, 1'($urandom));
                send_item(CMD_QUERY, ch, 1'($urandom), 1'($urandom));
            end else begin
                send_random();
            end
        end

        // Latch rises just before a wrap so that a later long period sees long echoes.
        if (!big && en != '0 && per >= 2) begin
            guard = 0;
            while (ranging.count != per - 1'b1 && guard < 64) begin
                send_item(CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
                guard++;
            end
            for (int c = 0; c < CHANNELS; c++) send_item(CMD_EDGE, 2'(c), 1'b1, 1'b0);
            send_item(CMD_TICK, 2'd0, 1'b0, 1'b0);
        end
        settle();
    endtask

    initial begin : stimulus
        int phase_no;
        ranging = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // All channels disabled after reset: ticks and edges change nothing.
        send_item(CMD_TICK, 2'd0, 1'b0, 1'b0);
        send_item(CMD_EDGE, 2'd0, 1'b1, 1'b0);
        send_item(CMD_QUERY, 2'd0, 1'b0, 1'b0);
        send_item(CMD_UNUSED, 2'd1, 1'b1, 1'b1);
        settle();

        // Short period, a write to the unused index, then an echo across a wrap.
        write_register(CFG_PERIOD, 24'd8);
        write_register(CFG_PULSE, 24'd3);
        write_register(CFG_ENABLE, 24'd7);
        write_register(CFG_UNUSED, 24'($urandom));
        repeat (5) send_item(CMD_TICK, 2'd1, 1'b0, 1'b0);
        send_item(CMD_EDGE, 2'd2, 1'b1, 1'b0);
        send_item(CMD_EDGE, 2'd0, 1'b1, 1'b0);
        repeat (5) send_item(CMD_TICK, 2'd2, 1'b0, 1'b0);
        send_item(CMD_EDGE, 2'd2, 1'b0, 1'b0);
        send_item(CMD_EDGE, 2'd0, 1'b0, 1'b0);
        send_item(CMD_QUERY, 2'd2, 1'b0, 1'b0);
        send_item(CMD_QUERY, 2'd2, 1'b0, 1'b1);
        send_item(CMD_QUERY, 2'd3, 1'b0, 1'b0);
        send_item(CMD_EDGE, 2'd3, 1'b1, 1'b1);
        send_item(CMD_TICK, 2'd0, 1'b0, 1'b0);
        settle();

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end
        settle();

        if (ranging.pending_words.size() != 0) begin
            ranging.report("words never delivered", 48'(ranging.pending_words.size()), '0);
        end
        $display("Sent %0d words over %0d register settings (%0d register writes).",
                 items_sent, phase_no + 2, cfg_writes);
        $display("Checked %0d result words, %0d with a nonzero distance.",
                 ranging.checked, ranging.nonzero_dist);
        if (ranging.errors == 0) begin
            $display("ultrasonic_echo_ranging_top_test: clean");
        end else begin
            $display("ultrasonic_echo_ranging_top_test: errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/uer_pkg.sv
rtl/uer_dist.sv
rtl/ultrasonic_echo_ranging_top.sv
test/ultrasonic_echo_ranging_top_test.sv
